// ===== rtl/core/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared widths, register indexes and stage types for the largest-square block.
// ----------------------------------------------------------------------------
package lsq_pkg;

  localparam int SIDE_W      = 11;
  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;

  localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // Control carried with an item from the read stage to the compute stage
  typedef struct packed {
    logic first_row;
    logic first_col;
    logic last_cell;
    logic fwd;
    logic cell_bit;
  } stage_ctrl_t;

endpackage

// ===== rtl/core/largest_square_of_ones_top.sv =====
// ----------------------------------------------------------------------------
// largest_square_of_ones_top
// Streaming maximal all-ones square over a row-major binary matrix.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+-------------------
//   input   | cell_bit                                  | in_valid/in_ready
//   output  | square_side, largest_side, matrix_done    | out_valid/out_ready
//   config  | cfg_index, cfg_data                       | cfg_write
//
// One item per cycle sustained while the output takes results: the row store
// read, then the min/update stage feeding the output register.
// The row store takes one read and one write per cycle; a read of the entry
// written in the same cycle is forwarded from the compute stage.
// Reset is synchronous and needs no clearing pass: the first row never reads
// the store. A stalled output holds the compute stage, which holds the input.
// ----------------------------------------------------------------------------
module largest_square_of_ones_top #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsq_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cell_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lsq_pkg::SIDE_W-1:0]      square_side,
  output logic [lsq_pkg::SIDE_W-1:0]      largest_side,
  output logic                            matrix_done
);

  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int SIDE_W  = lsq_pkg::SIDE_W;

  logic [lsq_pkg::CFG_W-1:0] row_count;
  logic [lsq_pkg::CFG_W-1:0] column_count;
  logic [CCNT_W-1:0]         cols_eff;
  logic [RCNT_W-1:0]         rows_eff;

  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic             col_last;
  logic             row_last;

  logic [SIDE_W-1:0] store [MAX_COLUMNS];
  logic [SIDE_W-1:0] mem_q;

  logic               s1_valid;
  lsq_pkg::stage_ctrl_t s1_ctrl;
  logic [COL_W-1:0]   s1_addr;
  logic [SIDE_W-1:0]  fwd_data;

  logic [SIDE_W-1:0] left_value;
  logic [SIDE_W-1:0] diagonal_value;
  logic [SIDE_W-1:0] best_side;

  logic              accept;
  logic              s1_adv;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] left;
  logic [SIDE_W-1:0] diag;
  logic [SIDE_W-1:0] min_ld;
  logic [SIDE_W-1:0] min3;
  logic [SIDE_W:0]   side_sum;
  logic [SIDE_W-1:0] side;
  logic [SIDE_W-1:0] best_next;

  // Clamp counts: zero acts as one, anything above MAX_COLUMNS or MAX_ROWS acts as that max
  always_comb begin
    if (column_count == '0) begin
      cols_eff = CCNT_W'(1);
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      cols_eff = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CCNT_W'(column_count);
    end
    if (row_count == '0) begin
      rows_eff = RCNT_W'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows_eff = RCNT_W'(MAX_ROWS);
    end else begin
      rows_eff = RCNT_W'(row_count);
    end
  end

  assign col_last = (CCNT_W'(col_pos) + CCNT_W'(1)) == cols_eff;
  assign row_last = (RCNT_W'(row_pos) + RCNT_W'(1)) == rows_eff;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // Config registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= lsq_pkg::CFG_W'(1024);
      column_count <= lsq_pkg::CFG_W'(1024);
      col_pos      <= '0;
      row_pos      <= '0;
    end else if (cfg_write) begin
      if (cfg_index == lsq_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data;
        col_pos   <= '0;
        row_pos   <= '0;
      end else if (cfg_index == lsq_pkg::REG_COLUMN_COUNT) begin
        column_count <= cfg_data;
        col_pos      <= '0;
        row_pos      <= '0;
      end
    end else if (accept) begin
      if (col_last) begin
        col_pos <= '0;
        row_pos <= row_last ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // Row store: read on accept, write back from the compute stage
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      store[s1_addr] <= side;
    end
    if (accept) begin
      mem_q <= store[col_pos];
    end
  end

  // Read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr             <= col_pos;
      s1_ctrl.first_row   <= row_pos == '0;
      s1_ctrl.first_col   <= col_pos == '0;
      s1_ctrl.last_cell   <= col_last && row_last;
      s1_ctrl.cell_bit    <= cell_bit;
      // catch the entry being written this very cycle
      s1_ctrl.fwd         <= s1_adv && (s1_addr == col_pos);
      fwd_data            <= side;
    end
  end

  // Compute stage
  always_comb begin
    if (s1_ctrl.first_row) begin
      up = '0;
    end else if (s1_ctrl.fwd) begin
      up = fwd_data;
    end else begin
      up = mem_q;
    end
    left     = s1_ctrl.first_col ? '0 : left_value;
    diag     = (s1_ctrl.first_row || s1_ctrl.first_col) ? '0 : diagonal_value;
    min_ld   = (left < diag) ? left : diag;
    min3     = (up < min_ld) ? up : min_ld;
    side_sum = {1'b0, min3} + (SIDE_W + 1)'(1);
    if (!s1_ctrl.cell_bit) begin
      side = '0;
    end else if (side_sum[SIDE_W]) begin
      side = lsq_pkg::SIDE_MAX;
    end else begin
      side = side_sum[SIDE_W-1:0];
    end
    best_next = (side > best_side) ? side : best_side;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_value     <= '0;
      diagonal_value <= '0;
      best_side      <= '0;
    end else if (cfg_write && (cfg_index == lsq_pkg::REG_ROW_COUNT ||
                               cfg_index == lsq_pkg::REG_COLUMN_COUNT)) begin
      left_value     <= '0;
      diagonal_value <= '0;
      best_side      <= '0;
    end else if (s1_adv) begin
      left_value     <= side;
      diagonal_value <= up;
      // drop the running best at the end of each matrix
      best_side      <= s1_ctrl.last_cell ? '0 : best_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      square_side  <= side;
      largest_side <= best_next;
      matrix_done  <= s1_ctrl.last_cell;
    end
  end

endmodule

// ===== tb/largest_square_of_ones_checker.sv =====
// ----------------------------------------------------------------------------
// largest_square_of_ones_checker
// Watches the config port and both item channels of the largest-square block,
// keeps its own copy of the row store and running state, predicts each
// result as a cell item is accepted and compares every returned result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module largest_square_of_ones_checker #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsq_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            cell_bit,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [lsq_pkg::SIDE_W-1:0]      square_side,
  input  logic [lsq_pkg::SIDE_W-1:0]      largest_side,
  input  logic                            matrix_done,
  output int                              pending,
  output int                              mismatch_count
);

  typedef struct packed {
    logic [lsq_pkg::SIDE_W-1:0] side;
    logic [lsq_pkg::SIDE_W-1:0] best;
    logic                       done;
  } square_result_t;

  square_result_t             expected_q[$];
  logic [lsq_pkg::SIDE_W-1:0] line_sides[MAX_COLUMNS];
  logic [lsq_pkg::SIDE_W-1:0] left_side;
  logic [lsq_pkg::SIDE_W-1:0] corner_side;
  logic [lsq_pkg::SIDE_W-1:0] best_so_far;
  logic [lsq_pkg::CFG_W-1:0]  rows_cfg;
  logic [lsq_pkg::CFG_W-1:0]  cols_cfg;
  int                         col_at;
  int                         row_at;
  int                         fails;

  function automatic int effective_count(logic [lsq_pkg::CFG_W-1:0] raw, int limit);
    if (raw == '0)
      return 1;
    if (int'(raw) > limit)
      return limit;
    return int'(raw);
  endfunction

  function automatic void clear_matrix();
    left_side   = '0;
    corner_side = '0;
    best_so_far = '0;
    col_at      = 0;
    row_at      = 0;
  endfunction

  // Side of the largest square ending at the next cell, plus running best
  function automatic square_result_t next_square(logic bit_in);
    int             rows;
    int             cols;
    int             c;
    int             r;
    int             up;
    int             lf;
    int             dg;
    int             s;
    square_result_t res;
    rows = effective_count(rows_cfg, MAX_ROWS);
    cols = effective_count(cols_cfg, MAX_COLUMNS);
    c = (col_at >= cols) ? 0 : col_at;
    r = (row_at >= rows) ? 0 : row_at;
    up = (r == 0) ? 0 : int'(line_sides[c % MAX_COLUMNS]);
    lf = (c == 0) ? 0 : int'(left_side);
    dg = (r == 0 || c == 0) ? 0 : int'(corner_side);
    if (bit_in) begin
      s = lf;
      if (up < s) s = up;
      if (dg < s) s = dg;
      s = s + 1;
      if (s > int'(lsq_pkg::SIDE_MAX)) s = int'(lsq_pkg::SIDE_MAX);
    end else begin
      s = 0;
    end
    if (s > int'(best_so_far))
      best_so_far = s[lsq_pkg::SIDE_W-1:0];
    corner_side = up[lsq_pkg::SIDE_W-1:0];
    left_side   = s[lsq_pkg::SIDE_W-1:0];
    line_sides[c % MAX_COLUMNS] = s[lsq_pkg::SIDE_W-1:0];
    res.side = s[lsq_pkg::SIDE_W-1:0];
    res.best = best_so_far;
    res.done = (c + 1 == cols) && (r + 1 == rows);
    if (res.done) begin
      clear_matrix();
    end else if (c + 1 == cols) begin
      col_at = 0;
      row_at = r + 1;
    end else begin
      col_at = c + 1;
      row_at = r;
    end
    return res;
  endfunction

  always @(posedge clk) begin : track
    square_result_t want;
    if (rst) begin
      clear_matrix();
      rows_cfg = lsq_pkg::CFG_W'(MAX_ROWS);
      cols_cfg = lsq_pkg::CFG_W'(MAX_COLUMNS);
      foreach (line_sides[i]) line_sides[i] = '0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lsq_pkg::REG_ROW_COUNT: begin
            rows_cfg = cfg_data;
            clear_matrix();
          end
          lsq_pkg::REG_COLUMN_COUNT: begin
            cols_cfg = cfg_data;
            clear_matrix();
          end
          default: ;  // no register behind this index
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(next_square(cell_bit));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          $error("square_side: expected no item, got %0d", square_side);
        end else begin
          want = expected_q.pop_front();
          if (square_side !== want.side) begin
            fails++;
            $error("square_side: expected %0d, got %0d", want.side, square_side);
          end
          if (largest_side !== want.best) begin
            fails++;
            $error("largest_side: expected %0d, got %0d", want.best, largest_side);
          end
          if (matrix_done !== want.done) begin
            fails++;
            $error("matrix_done: expected %0d, got %0d", want.done, matrix_done);
          end
        end
      end
    end
    pending        <= expected_q.size();
    mismatch_count <= fails;
  end

endmodule

// ===== tb/largest_square_of_ones_top_tb.sv =====
// ----------------------------------------------------------------------------
// largest_square_of_ones_top_tb
// Streams binary matrices of many shapes into the largest-square block, with
// random gaps and output stalls, and lets the checker compare each result.
// A short directed part covers tiny and clamped shapes and writes to unused
// indexes; the widest case runs a full 1x1024 matrix; the rest is mostly
// whole random matrices with some partial ones and odd settings, and a calm
// tail with no idling.
// ----------------------------------------------------------------------------
module largest_square_of_ones_top_tb;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int RANDOM_CELLS = 80;
  localparam int CALM_CELLS   = 30;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [lsq_pkg::CFG_INDEX_W-1:0] REG_SPARE_LOW  = 2'd2;
  localparam logic [lsq_pkg::CFG_INDEX_W-1:0] REG_SPARE_HIGH = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [lsq_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [lsq_pkg::CFG_W-1:0]       cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic                            cell_bit;
  logic                            out_valid;
  logic                            out_ready;
  logic [lsq_pkg::SIDE_W-1:0]      square_side;
  logic [lsq_pkg::SIDE_W-1:0]      largest_side;
  logic                            matrix_done;
  int                              pending;
  int                              mismatch_count;

  bit gaps_on;
  bit stalls_on;
  bit squeeze;
  int cells_sent;
  int cycles;

  largest_square_of_ones_top #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cell_bit    (cell_bit),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .square_side (square_side),
    .largest_side(largest_side),
    .matrix_done (matrix_done)
  );

  largest_square_of_ones_checker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) square_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cell_bit      (cell_bit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .square_side   (square_side),
    .largest_side  (largest_side),
    .matrix_done   (matrix_done),
    .pending       (pending),
    .mismatch_count(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: ready in random runs, stalls in bursts, one long hold-off
  initial begin : result_side
    forever begin
      if (squeeze) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_cell(input logic value);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_bit <= value;
    do @(posedge clk); while (!in_ready);
    cells_sent++;
  endtask

  task automatic send_cells(input int count, input int density);
    for (int i = 0; i < count; i++)
      send_cell($urandom_range(0, 99) < density);
  endtask

  // Drop valid and wait until every predicted item has come back
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [lsq_pkg::CFG_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input logic [lsq_pkg::CFG_W-1:0] rows,
                           input logic [lsq_pkg::CFG_W-1:0] cols);
    write_reg(lsq_pkg::REG_ROW_COUNT, rows);
    write_reg(lsq_pkg::REG_COLUMN_COUNT, cols);
  endtask

  function automatic int pick_density();
    case ($urandom_range(0, 3))
      0:       return 30;
      1:       return 70;
      2:       return 90;
      default: return 100;
    endcase
  endfunction

  initial begin : stimulus
    int random_start;
    int rows;
    int cols;
    int kind;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    cell_bit  <= 1'b0;
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    squeeze   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Start of the first row of the 1024x1024 matrix left by reset
    send_cell(1'b1);
    send_cell(1'b1);
    send_cell(1'b0);
    drain();

    // Zero counts act as one: every cell is a whole matrix
    set_shape('0, '0);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
    drain();

    // All ones: sides grow to three, then the next matrix starts afresh
    set_shape(11'd3, 11'd4);
    send_cells(14, 100);
    drain();

    // Unused indexes must not restart the matrix
    write_reg(REG_SPARE_LOW, 11'h7FF);
    write_reg(REG_SPARE_HIGH, 11'h555);
    send_cells(3, 100);
    drain();

    // Widest row, column count clamped; hold the output to back up the input
    set_shape('0, 11'h7FF);
    squeeze = 1'b1;
    send_cells(MAX_COLUMNS + 1, 90);
    drain();

    random_start = cells_sent;
    while (cells_sent - random_start < RANDOM_CELLS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        // Raw settings over the whole field range, then a short run of cells
        set_shape(lsq_pkg::CFG_W'($urandom_range(0, 2047)),
                  lsq_pkg::CFG_W'($urandom_range(0, 2047)));
        send_cells($urandom_range(20, 40), 50);
      end else if (kind == 1) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                  lsq_pkg::CFG_W'($urandom_range(0, 2047)));
        send_cells($urandom_range(1, 20), pick_density());
      end else begin
        rows = $urandom_range(1, 12);
        cols = $urandom_range(1, 12);
        if (kind == 2)
          write_reg(lsq_pkg::REG_COLUMN_COUNT, lsq_pkg::CFG_W'(cols));
        else
          set_shape(lsq_pkg::CFG_W'(rows), lsq_pkg::CFG_W'(cols));
        repeat ($urandom_range(1, 3))
          send_cells(rows * cols, pick_density());
        // Break off a matrix midway now and then
        if ($urandom_range(0, 9) == 0)
          send_cells($urandom_range(1, rows * cols), pick_density());
      end
      drain();
    end

    // Last part: no gaps and no stalls; let any running stall burst end first
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (12) @(posedge clk);
    set_shape(11'd5, 11'd6);
    send_cells(CALM_CELLS, 80);
    drain();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
